// File: design/kpd_pkg.sv
// Package with the shared types and codes of the knock pattern detector.
package kpd_pkg;

   localparam int unsigned FIELD_SAMPLE_BITS = 12;
   localparam int unsigned SENSOR_COUNT      = 3;
   localparam int unsigned CSR_INDEX_BITS    = 3;
   localparam int unsigned CSR_DATA_BITS     = 32;

   typedef enum logic [1:0] {
      OP_TICK  = 2'd0,
      OP_CLEAR = 2'd1,
      OP_SOLVE = 2'd2
   } op_type;

   typedef enum logic [1:0] {
      VERDICT_NONE  = 2'd0,
      VERDICT_MATCH = 2'd1,
      VERDICT_WRONG = 2'd2
   } verdict_type;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_THRESHOLD_A    = 3'd0,
      CSR_THRESHOLD_B    = 3'd1,
      CSR_THRESHOLD_C    = 3'd2,
      CSR_WINDOW_MS      = 3'd3,
      CSR_DEBOUNCE_MS    = 3'd4,
      CSR_QUIET_TIMEOUT  = 3'd5,
      CSR_PATTERN_LEN    = 3'd6,
      CSR_PATTERN_WORD   = 3'd7
   } csr_index_type;

   typedef struct packed {
      logic [1:0]  opcode;
      logic [31:0] now_ms;
      logic        active;
      logic [11:0] sample_a;
      logic [11:0] sample_b;
      logic [11:0] sample_c;
   } req_type;

   typedef struct packed {
      logic        knock_valid;
      logic [1:0]  knock_sensor;
      verdict_type verdict;
      logic        is_solved;
      logic [15:0] attempt_count;
      logic [4:0]  knocks_held;
      logic        window_open;
   } rsp_type;

endpackage

// File: design/knock_pattern_detector.sv
// Top level of the knock pattern detector: capture, knock decision, sequence judge.
//
// Each result is registered, in the result register or, while the port is stalled,
// in the skid register. Throughput: one item per cycle while the skid register is
// empty; all of an item's work is one pass of logic from the state registers.
// A two-entry output buffer (result register plus skid register) lets the next
// input transfer happen while a result still waits on rsp_stall.
// Reset is synchronous and active high; it clears the detector state and the valid
// flags and loads the register defaults (pattern_len of one, everything else zero).
module knock_pattern_detector #(
   parameter int unsigned MAX_KNOCKS  = 16,
   parameter int unsigned SAMPLE_BITS = 12
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  kpd_pkg::req_type                   req_data,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output kpd_pkg::rsp_type                   rsp_data,
   input  logic                               csr_wr_en,
   input  logic [kpd_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [kpd_pkg::CSR_DATA_BITS-1:0]  csr_wdata
);
   import kpd_pkg::*;

   // Samples arrive as 12-bit fields; only the low SAMPLE_BITS of them count.
   localparam int unsigned EB = (SAMPLE_BITS < FIELD_SAMPLE_BITS) ?
                                SAMPLE_BITS : FIELD_SAMPLE_BITS;
   localparam int unsigned CW = $clog2(MAX_KNOCKS + 1);
   localparam int unsigned IW = (MAX_KNOCKS > 1) ? $clog2(MAX_KNOCKS) : 1;

   // Configuration registers.
   logic [11:0] threshold_ff [SENSOR_COUNT];
   logic [15:0] window_ms_ff;
   logic [15:0] debounce_ms_ff;
   logic [15:0] quiet_timeout_ff;
   logic [4:0]  pattern_len_ff;
   logic [31:0] pattern_word_ff;

   // Detector state and its next values.
   logic          capture_open_ff, capture_open_in;
   logic [31:0]   capture_start_ff, capture_start_in;
   logic [EB-1:0] capture_peak_ff [SENSOR_COUNT];
   logic [EB-1:0] capture_peak_in [SENSOR_COUNT];
   logic [31:0]   last_knock_ff, last_knock_in;
   logic [CW-1:0] knock_count_ff, knock_count_in;
   logic [31:0]   last_activity_ff, last_activity_in;
   logic          solved_ff, solved_in;
   logic [15:0]   wrong_tries_ff, wrong_tries_in;
   logic [1:0]    knock_store_ff [MAX_KNOCKS];

   // Sequence store write request.
   logic          store_we;
   logic [IW-1:0] store_idx;
   logic [1:0]    store_val;

   // Output buffer: the result register feeds the port, the skid register
   // catches a result produced while the port is stalled.
   logic    out_valid_ff, out_valid_in;
   rsp_type out_data_ff, out_data_in;
   logic    skid_valid_ff, skid_valid_in;
   rsp_type skid_data_ff, skid_data_in;
   rsp_type result;

   logic req_fire;
   logic out_take;

   // Input transfers only stop while the skid register is occupied, which
   // keeps the stall free of any combinational path from rsp_stall.
   assign req_stall = skid_valid_ff;
   assign req_fire  = req_valid && !req_stall;
   assign out_take  = out_valid_ff && !rsp_stall;
   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

   // Configuration writes; every index value names a register.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < SENSOR_COUNT; i++) begin
            threshold_ff[i] <= '0;
         end
         window_ms_ff     <= '0;
         debounce_ms_ff   <= '0;
         quiet_timeout_ff <= '0;
         pattern_len_ff   <= 5'd1;
         pattern_word_ff  <= '0;
      end else if (csr_wr_en) begin
         case (csr_index_type'(csr_index))
            CSR_THRESHOLD_A:   threshold_ff[0]  <= csr_wdata[11:0];
            CSR_THRESHOLD_B:   threshold_ff[1]  <= csr_wdata[11:0];
            CSR_THRESHOLD_C:   threshold_ff[2]  <= csr_wdata[11:0];
            CSR_WINDOW_MS:     window_ms_ff     <= csr_wdata[15:0];
            CSR_DEBOUNCE_MS:   debounce_ms_ff   <= csr_wdata[15:0];
            CSR_QUIET_TIMEOUT: quiet_timeout_ff <= csr_wdata[15:0];
            CSR_PATTERN_LEN:   pattern_len_ff   <= csr_wdata[4:0];
            CSR_PATTERN_WORD:  pattern_word_ff  <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   // One pass over an item: a clear, a solve, or for an active tick the sensor
   // scan, window expiry with peak pick, knock acceptance, quiet-time judgment.
   always_comb begin
      logic [EB-1:0] samp [SENSOR_COUNT];
      logic [EB-1:0] thr  [SENSOR_COUNT];
      logic [1:0]    store_view [MAX_KNOCKS];
      logic [EB-1:0] best_val;
      logic [1:0]    best_idx;
      logic          best_found;
      logic [EB-1:0] best_thr;
      logic          seq_match;
      logic [31:0]   now;

      samp[0] = req_data.sample_a[EB-1:0];
      samp[1] = req_data.sample_b[EB-1:0];
      samp[2] = req_data.sample_c[EB-1:0];
      for (int i = 0; i < SENSOR_COUNT; i++) begin
         thr[i] = threshold_ff[i][EB-1:0];
      end
      for (int i = 0; i < MAX_KNOCKS; i++) begin
         store_view[i] = knock_store_ff[i];
      end
      now        = req_data.now_ms;
      best_val   = '0;
      best_idx   = '0;
      best_found = 1'b0;
      best_thr   = '0;
      seq_match  = 1'b0;

      capture_open_in  = capture_open_ff;
      capture_start_in = capture_start_ff;
      for (int i = 0; i < SENSOR_COUNT; i++) begin
         capture_peak_in[i] = capture_peak_ff[i];
      end
      last_knock_in    = last_knock_ff;
      knock_count_in   = knock_count_ff;
      last_activity_in = last_activity_ff;
      solved_in        = solved_ff;
      wrong_tries_in   = wrong_tries_ff;
      store_we         = 1'b0;
      store_idx        = knock_count_ff[IW-1:0];
      store_val        = '0;

      result               = '0;
      result.verdict       = VERDICT_NONE;

      case (op_type'(req_data.opcode))
         OP_CLEAR: begin
            capture_open_in  = 1'b0;
            last_knock_in    = '0;
            knock_count_in   = '0;
            last_activity_in = '0;
            solved_in        = 1'b0;
            wrong_tries_in   = '0;
         end
         OP_SOLVE: begin
            solved_in = 1'b1;
         end
         OP_TICK: begin
            if (req_data.active) begin
               // Sensors in order: the first hit opens the window, later
               // samples (same tick included) only raise the peaks.
               for (int i = 0; i < SENSOR_COUNT; i++) begin
                  if (!capture_open_in) begin
                     if (samp[i] >= thr[i]) begin
                        capture_open_in  = 1'b1;
                        capture_start_in = now;
                        for (int j = 0; j < SENSOR_COUNT; j++) begin
                           capture_peak_in[j] = '0;
                        end
                        capture_peak_in[i] = samp[i];
                     end
                  end else if (samp[i] > capture_peak_in[i]) begin
                     capture_peak_in[i] = samp[i];
                  end
               end

               if (capture_open_in &&
                   ((now - capture_start_in) >= {16'd0, window_ms_ff})) begin
                  capture_open_in = 1'b0;
                  // The first sensor with the strictly largest nonzero peak wins.
                  for (int i = 0; i < SENSOR_COUNT; i++) begin
                     if (capture_peak_in[i] > best_val) begin
                        best_val   = capture_peak_in[i];
                        best_idx   = 2'(i);
                        best_found = 1'b1;
                        best_thr   = thr[i];
                     end
                  end
                  if (best_found && (best_val >= best_thr) &&
                      ((now - last_knock_ff) >= {16'd0, debounce_ms_ff})) begin
                     last_knock_in       = now;
                     result.knock_valid  = 1'b1;
                     result.knock_sensor = best_idx;
                     last_activity_in    = now;
                     // A knock that finds the store full still counts for
                     // debounce and activity but is not recorded.
                     if (knock_count_ff < CW'(MAX_KNOCKS)) begin
                        store_we   = 1'b1;
                        store_val  = best_idx;
                        store_view[store_idx] = best_idx;
                        knock_count_in = knock_count_ff + CW'(1);
                     end
                  end
               end

               if ((knock_count_in != '0) &&
                   ((now - last_activity_in) >= {16'd0, quiet_timeout_ff})) begin
                  seq_match = (5'(knock_count_in) == pattern_len_ff);
                  for (int i = 0; i < MAX_KNOCKS; i++) begin
                     if ((CW'(i) < knock_count_in) &&
                         (store_view[i] != pattern_word_ff[2*i +: 2])) begin
                        seq_match = 1'b0;
                     end
                  end
                  if (seq_match) begin
                     solved_in      = 1'b1;
                     result.verdict = VERDICT_MATCH;
                  end else begin
                     if (wrong_tries_ff != 16'hFFFF) begin
                        wrong_tries_in = wrong_tries_ff + 16'd1;
                     end
                     result.verdict = VERDICT_WRONG;
                  end
                  knock_count_in   = '0;
                  last_activity_in = '0;
               end
            end
         end
         default: begin
         end
      endcase

      result.is_solved     = solved_in;
      result.attempt_count = wrong_tries_in;
      result.knocks_held   = 5'(knock_count_in);
      result.window_open   = capture_open_in;
   end

   // State registers advance on each input transfer.
   always_ff @(posedge clock) begin
      if (reset) begin
         capture_open_ff  <= 1'b0;
         capture_start_ff <= '0;
         for (int i = 0; i < SENSOR_COUNT; i++) begin
            capture_peak_ff[i] <= '0;
         end
         last_knock_ff    <= '0;
         knock_count_ff   <= '0;
         last_activity_ff <= '0;
         solved_ff        <= 1'b0;
         wrong_tries_ff   <= '0;
      end else if (req_fire) begin
         capture_open_ff  <= capture_open_in;
         capture_start_ff <= capture_start_in;
         for (int i = 0; i < SENSOR_COUNT; i++) begin
            capture_peak_ff[i] <= capture_peak_in[i];
         end
         last_knock_ff    <= last_knock_in;
         knock_count_ff   <= knock_count_in;
         last_activity_ff <= last_activity_in;
         solved_ff        <= solved_in;
         wrong_tries_ff   <= wrong_tries_in;
      end
   end

   // The sequence store holds no reset value; entries past the count are
   // never compared.
   always_ff @(posedge clock) begin
      if (req_fire && store_we) begin
         knock_store_ff[store_idx] <= store_val;
      end
   end

   // Output buffer control.
   always_comb begin
      out_valid_in  = out_valid_ff;
      out_data_in   = out_data_ff;
      skid_valid_in = skid_valid_ff;
      skid_data_in  = skid_data_ff;
      if (skid_valid_ff) begin
         if (out_take) begin
            out_data_in   = skid_data_ff;
            skid_valid_in = 1'b0;
         end
      end else if (req_fire) begin
         if (!out_valid_ff || out_take) begin
            out_valid_in = 1'b1;
            out_data_in  = result;
         end else begin
            skid_valid_in = 1'b1;
            skid_data_in  = result;
         end
      end else if (out_take) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_data_ff  <= out_data_in;
      skid_data_ff <= skid_data_in;
   end

endmodule

// File: design/kpd_checker.sv
// Port checker for the knock pattern detector and its bind statement.
module kpd_checker (
   input logic             clock,
   input logic             reset,
   input logic             rsp_valid,
   input logic             rsp_stall,
   input kpd_pkg::rsp_type rsp_data
);
   import kpd_pkg::*;

   // A stalled result stays offered and unchanged.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled result changed or was dropped");

   // Reset leaves no result pending.
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid right after reset");

   // A result without a knock reports sensor zero, and a match is always solved.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.knock_valid |-> rsp_data.knock_sensor == 2'd0)
      else $error("sensor reported without a knock");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.verdict == VERDICT_MATCH) |-> rsp_data.is_solved)
      else $error("matched verdict without solved flag");

   // A judged sequence leaves the store empty.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.verdict != VERDICT_NONE) |-> rsp_data.knocks_held == 5'd0)
      else $error("store not emptied after judgment");

endmodule

bind knock_pattern_detector kpd_checker u_kpd_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);

// File: tb/sv/knock_pattern_detector_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench of the knock pattern detector: directed and random knock traffic.
module knock_pattern_detector_tb;
   import kpd_pkg::*;

   // Opcode value that the block has no meaning for; it must be ignored.
   localparam logic [1:0]  OP_UNUSED    = 2'd3;
   // A two-bit pattern entry that names no sensor.
   localparam logic [1:0]  NO_SENSOR    = 2'd3;
   localparam int unsigned STORE_DEPTH  = 16;
   localparam int unsigned IDLE_PERCENT = 29;
   localparam int unsigned HOLD_CYCLES  = 60;
   localparam int unsigned DRAIN_CYCLES = 4;
   localparam int unsigned RANDOM_ITEMS = 1000;
   localparam int unsigned PHASES       = 5;
   localparam int unsigned CYCLE_LIMIT  = 200000;
   localparam int unsigned NOISE_MAX    = 400;
   localparam int unsigned REQ_BITS     = $bits(req_type);

   logic         clock     = 1'b0;
   logic         reset     = 1'b1;
   logic         req_valid = 1'b0;
   logic         req_stall;
   req_type      req_data  = '0;
   logic         rsp_valid;
   logic         rsp_stall = 1'b0;
   rsp_type      rsp_data;
   logic         csr_wr_en = 1'b0;
   logic [CSR_INDEX_BITS-1:0] csr_index = '0;
   logic [CSR_DATA_BITS-1:0]  csr_wdata = '0;

   knock_pattern_detector dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // Register copies held by the predictor. They follow every register write.
   logic [11:0] thr_level [SENSOR_COUNT] = '{default: '0};
   logic [15:0] win_len      = '0;
   logic [15:0] debounce_len = '0;
   logic [15:0] quiet_len    = '0;
   logic [4:0]  pat_len      = 5'd1;
   logic [31:0] pat_word     = '0;

   // Detector state as the predictor sees it. The knock store is never read
   // at an entry that has not been written, so it needs no reset value.
   logic        cap_open       = 1'b0;
   logic [31:0] cap_start      = '0;
   logic [11:0] cap_peak [SENSOR_COUNT] = '{default: '0};
   logic [31:0] last_knock_at  = '0;
   logic [1:0]  knock_seq [STORE_DEPTH];
   logic [4:0]  seq_count      = '0;
   logic [31:0] last_active_at = '0;
   logic        solved         = 1'b0;
   logic [15:0] wrong_tries    = '0;

   // Outcomes predicted for accepted items, oldest first.
   rsp_type     expected_outcomes [$];
   rsp_type     oldest;

   // Stimulus bookkeeping.
   logic [31:0] tick_time      = '0;
   int          items_sent     = 0;
   int          mismatches     = 0;
   int          cycle_count    = 0;
   bit          sender_idles   = 1'b1;
   bit          receiver_idles = 1'b1;
   bit          hold_request   = 1'b0;
   int          hold_left      = 0;

   // Works out the outcome of one item and advances the predicted state.
   function automatic rsp_type predict_outcome(input req_type item);
      logic [11:0] level [SENSOR_COUNT];
      logic [11:0] best_val;
      logic [31:0] elapsed;
      int          best;
      int          i;
      int          j;
      bit          matched;
      rsp_type     res;
      res = '0;
      res.verdict = VERDICT_NONE;
      level[0] = item.sample_a;
      level[1] = item.sample_b;
      level[2] = item.sample_c;
      if (item.opcode == OP_CLEAR) begin
         // A clear keeps the capture start, the peaks and the registers.
         cap_open       = 1'b0;
         last_knock_at  = '0;
         seq_count      = '0;
         last_active_at = '0;
         solved         = 1'b0;
         wrong_tries    = '0;
      end else if (item.opcode == OP_SOLVE) begin
         solved = 1'b1;
      end else if (item.opcode == OP_TICK && item.active) begin
         // Sensors are scanned in order; the first hit opens the window and
         // every later sample, even in the same tick, only raises peaks.
         for (i = 0; i < SENSOR_COUNT; i++) begin
            if (!cap_open) begin
               if (level[i] >= thr_level[i]) begin
                  cap_open  = 1'b1;
                  cap_start = item.now_ms;
                  for (j = 0; j < SENSOR_COUNT; j++) cap_peak[j] = '0;
                  cap_peak[i] = level[i];
               end
            end else if (level[i] > cap_peak[i]) begin
               cap_peak[i] = level[i];
            end
         end
         elapsed = item.now_ms - cap_start;
         if (cap_open && elapsed >= win_len) begin
            // The first sensor with the strictly largest nonzero peak wins.
            cap_open = 1'b0;
            best     = -1;
            best_val = '0;
            for (i = 0; i < SENSOR_COUNT; i++) begin
               if (cap_peak[i] > best_val) begin
                  best_val = cap_peak[i];
                  best     = i;
               end
            end
            elapsed = item.now_ms - last_knock_at;
            if (best >= 0 && best_val >= thr_level[best] && elapsed >= debounce_len) begin
               last_knock_at    = item.now_ms;
               res.knock_valid  = 1'b1;
               res.knock_sensor = 2'(best);
               // A full store still accepts the knock but does not keep it.
               if (seq_count < STORE_DEPTH) begin
                  knock_seq[seq_count] = 2'(best);
                  seq_count++;
               end
               last_active_at = item.now_ms;
            end
         end
         elapsed = item.now_ms - last_active_at;
         if (seq_count != 0 && elapsed >= quiet_len) begin
            matched = (seq_count == pat_len);
            for (i = 0; i < seq_count; i++) begin
               if (knock_seq[i] != pat_word[2*i +: 2]) matched = 1'b0;
            end
            if (matched) begin
               solved      = 1'b1;
               res.verdict = VERDICT_MATCH;
            end else begin
               if (wrong_tries != 16'hFFFF) wrong_tries++;
               res.verdict = VERDICT_WRONG;
            end
            seq_count      = '0;
            last_active_at = '0;
         end
      end
      res.is_solved     = solved;
      res.attempt_count = wrong_tries;
      res.knocks_held   = seq_count;
      res.window_open   = cap_open;
      return res;
   endfunction

   // Offers one item, optionally after a random gap, and waits for its transfer.
   task automatic send_item(input req_type item);
      while (sender_idles && $urandom_range(99) < IDLE_PERCENT) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      expected_outcomes.push_back(predict_outcome(item));
      items_sent++;
   endtask

   // Sends a sensor tick at the given time.
   task automatic tick_at(input logic [31:0] t, input logic act,
                          input logic [11:0] a, input logic [11:0] b, input logic [11:0] c);
      req_type item;
      tick_time     = t;
      item.opcode   = OP_TICK;
      item.now_ms   = t;
      item.active   = act;
      item.sample_a = a;
      item.sample_b = b;
      item.sample_c = c;
      send_item(item);
   endtask

   // An item with random content and the given opcode at the current time.
   function automatic req_type random_item(input logic [1:0] op);
      req_type r;
      r        = REQ_BITS'({$urandom(), $urandom(), $urandom()});
      r.opcode = op;
      r.now_ms = tick_time;
      r.active = ($urandom_range(99) < 80);
      return r;
   endfunction

   // Mostly low background noise, now and then a sample of any size.
   function automatic logic [11:0] noise_sample();
      if ($urandom_range(99) < 10) return 12'($urandom());
      return 12'($urandom_range(0, NOISE_MAX));
   endfunction

   // Waits until every result has arrived and the block has settled.
   task automatic drain();
      req_valid <= 1'b0;
      while (expected_outcomes.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_register(input csr_index_type idx, input logic [31:0] value);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      case (idx)
         CSR_THRESHOLD_A:   thr_level[0] = value[11:0];
         CSR_THRESHOLD_B:   thr_level[1] = value[11:0];
         CSR_THRESHOLD_C:   thr_level[2] = value[11:0];
         CSR_WINDOW_MS:     win_len      = value[15:0];
         CSR_DEBOUNCE_MS:   debounce_len = value[15:0];
         CSR_QUIET_TIMEOUT: quiet_len    = value[15:0];
         CSR_PATTERN_LEN:   pat_len      = value[4:0];
         CSR_PATTERN_WORD:  pat_word     = value;
         default: ;
      endcase
   endtask

   // Rewrites every register once the block is idle. Bits above a register's
   // width carry junk, since the block must ignore them.
   task automatic write_setup(input logic [11:0] thr_a, input logic [11:0] thr_b,
                              input logic [11:0] thr_c, input logic [15:0] win,
                              input logic [15:0] deb, input logic [15:0] quiet,
                              input logic [4:0] plen, input logic [31:0] pword);
      drain();
      write_register(CSR_THRESHOLD_A,   {20'($urandom()), thr_a});
      write_register(CSR_THRESHOLD_B,   {20'($urandom()), thr_b});
      write_register(CSR_THRESHOLD_C,   {20'($urandom()), thr_c});
      write_register(CSR_WINDOW_MS,     {16'($urandom()), win});
      write_register(CSR_DEBOUNCE_MS,   {16'($urandom()), deb});
      write_register(CSR_QUIET_TIMEOUT, {16'($urandom()), quiet});
      write_register(CSR_PATTERN_LEN,   {27'($urandom()), plen});
      write_register(CSR_PATTERN_WORD,  pword);
      csr_wr_en <= 1'b0;
   endtask

   // One knock on the given sensor: a hit, ticks until the window expires,
   // then a gap that mostly respects the debounce time.
   task automatic send_knock(input int sensor);
      logic [11:0] level [SENSOR_COUNT];
      logic [31:0] opened;
      int          i;
      for (i = 0; i < SENSOR_COUNT; i++) level[i] = noise_sample();
      level[sensor] = 12'($urandom_range(thr_level[sensor], 4095));
      opened = tick_time;
      tick_at(tick_time, 1'b1, level[0], level[1], level[2]);
      while (tick_time - opened < {16'd0, win_len}) begin
         tick_at(tick_time + $urandom_range(1, 3), 1'b1,
                 noise_sample(), noise_sample(), noise_sample());
      end
      if ($urandom_range(99) < 15) tick_time += $urandom_range(0, debounce_len);
      else tick_time += debounce_len + $urandom_range(1, 4);
   endtask

   // A knock sequence near the pattern length, mostly following the pattern,
   // closed by a quiet stretch so that it gets judged.
   task automatic knock_attempt();
      int          length;
      int          i;
      int unsigned sensor;
      if (pat_len >= 1 && pat_len <= STORE_DEPTH) length = int'(pat_len);
      else length = $urandom_range(1, 5);
      length = length + int'($urandom_range(0, 2)) - 1;
      if (length < 1) length = 1;
      for (i = 0; i < length; i++) begin
         if (i < STORE_DEPTH && $urandom_range(99) < 80 && pat_word[2*i +: 2] != NO_SENSOR)
            sensor = int'(pat_word[2*i +: 2]);
         else
            sensor = $urandom_range(0, 2);
         send_knock(sensor);
      end
      repeat ($urandom_range(0, 2)) begin
         tick_at(tick_time + $urandom_range(0, 3), 1'b1, 12'($urandom_range(0, NOISE_MAX)),
                 12'($urandom_range(0, NOISE_MAX)), 12'($urandom_range(0, NOISE_MAX)));
      end
      tick_at(tick_time + quiet_len + $urandom_range(0, 4), 1'b1,
              12'($urandom_range(0, NOISE_MAX)), 12'($urandom_range(0, NOISE_MAX)),
              12'($urandom_range(0, NOISE_MAX)));
   endtask

   // A loose item: any opcode, random activity and samples, random time jump.
   task automatic send_noise();
      int unsigned pick;
      logic [1:0]  op;
      pick = $urandom_range(99);
      if (pick < 6) op = OP_CLEAR;
      else if (pick < 11) op = OP_SOLVE;
      else if (pick < 16) op = OP_UNUSED;
      else op = OP_TICK;
      if ($urandom_range(99) < 5) tick_time += $urandom();
      else tick_time += $urandom_range(0, 40);
      send_item(random_item(op));
   endtask

   // With the registers at their reset values every tick opens and closes a
   // window at once, and a single knock on sensor zero is the whole pattern.
   task automatic test_reset_defaults();
      tick_at(32'd1000, 1'b1, 12'd0, 12'd0, 12'd0);          // all peaks zero: no knock
      tick_at(32'd1001, 1'b1, 12'hFFF, 12'd0, 12'd0);        // knock zero, judged at once
      send_item(random_item(OP_UNUSED));
      tick_at(32'd1002, 1'b0, 12'hFFF, 12'hFFF, 12'hFFF);    // inactive tick
      send_item(random_item(OP_CLEAR));
      tick_at(32'd1003, 1'b1, 12'd0, 12'hFFF, 12'hFFF);      // tie goes to sensor one
      send_item(random_item(OP_SOLVE));
      send_item(random_item(OP_CLEAR));
   endtask

   // A three-knock pattern across the wrap of the millisecond time, with a
   // candidate below its threshold and a knock inside the debounce time.
   task automatic test_knock_sequence();
      logic [31:0] base;
      base = 32'hFFFF_FFF0;
      // Pattern positions: sensor zero, then two, then one.
      write_setup(12'd1000, 12'd3000, 12'd1000, 16'd4, 16'd10, 16'd30, 5'd3,
                  {26'($urandom()), 6'b01_10_00});
      tick_at(base,      1'b1, 12'd2000, 12'd100, 12'd50);
      tick_at(base + 2,  1'b1, 12'd2500, 12'd0, 12'd0);
      tick_at(base + 4,  1'b1, 12'd0, 12'd0, 12'd0);         // knock zero
      tick_at(base + 16, 1'b1, 12'd1200, 12'd2500, 12'd0);   // sensor one peaks low
      tick_at(base + 20, 1'b1, 12'd0, 12'd0, 12'd0);         // below threshold: dropped
      tick_at(base + 22, 1'b1, 12'd0, 12'd0, 12'd3500);
      tick_at(base + 26, 1'b1, 12'd0, 12'd0, 12'd0);         // knock two
      tick_at(base + 28, 1'b1, 12'd0, 12'd3600, 12'd0);
      tick_at(base + 32, 1'b1, 12'd0, 12'd0, 12'd0);         // too soon: debounced
      tick_at(base + 40, 1'b1, 12'd0, 12'd3900, 12'd200);
      tick_at(base + 44, 1'b1, 12'd0, 12'd0, 12'd0);         // knock one
      tick_at(base + 60, 1'b1, 12'd0, 12'd0, 12'd0);         // still within quiet time
      tick_at(base + 74, 1'b1, 12'd0, 12'd0, 12'd0);         // judged: match
   endtask

   // Every register at its top value; a pattern length of 31 can never match.
   task automatic test_register_extremes();
      logic [31:0] base;
      base = 32'h8000_0000;
      write_setup(12'hFFF, 12'hFFF, 12'hFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 5'd31,
                  32'hFFFF_FFFF);
      tick_at(base,             1'b1, 12'hFFE, 12'hFFE, 12'hFFF);
      tick_at(base + 65534,     1'b1, 12'd0, 12'd0, 12'd0);  // window still open
      tick_at(base + 65535,     1'b1, 12'd0, 12'd0, 12'd0);  // knock two
      tick_at(base + 2 * 65535, 1'b1, 12'd0, 12'd0, 12'd0);  // judged: wrong
   endtask

   // The receiver holds off for a long stretch while items keep coming
   // back to back, so the block fills and stalls its input.
   task automatic test_backpressure();
      sender_idles = 1'b0;
      hold_request = 1'b1;
      repeat (20) send_noise();
      sender_idles = 1'b1;
   endtask

   // Random phases, each with its own register setting. The middle phase
   // runs with no idling on either side, one phase overfills the knock
   // store and the last one uses a pattern length that cannot match.
   task automatic test_random_traffic();
      int          phase;
      int          i;
      int          stop_at;
      logic [15:0] win;
      logic [15:0] deb;
      logic [4:0]  plen;
      logic [31:0] pword;
      for (phase = 0; phase < PHASES; phase++) begin
         win = 16'($urandom_range(0, 6));
         deb = 16'($urandom_range(0, 12));
         if (phase == 3) plen = 5'd16;
         else if (phase == 4) plen = ($urandom_range(1) == 0) ? 5'd0 : 5'($urandom_range(17, 31));
         else plen = 5'($urandom_range(1, 6));
         pword = $urandom();
         for (i = 0; i < STORE_DEPTH; i++) pword[2*i +: 2] = 2'($urandom_range(0, 2));
         // The quiet time outlasts the gap between knocks of one sequence.
         write_setup(12'($urandom_range(600, 3500)), 12'($urandom_range(600, 3500)),
                     12'($urandom_range(600, 3500)), win, deb,
                     16'(win + deb + $urandom_range(12, 40)), plen, pword);
         sender_idles   = (phase != 2);
         receiver_idles = (phase != 2);
         stop_at = items_sent + RANDOM_ITEMS / PHASES;
         while (items_sent < stop_at) begin
            if ($urandom_range(99) < 85) knock_attempt();
            else send_noise();
         end
      end
      sender_idles   = 1'b1;
      receiver_idles = 1'b1;
   endtask

   // Result side: random stalls, and one long hold-off counted here.
   always @(posedge clock) begin
      if (hold_left != 0) begin
         rsp_stall <= 1'b1;
         hold_left <= hold_left - 1;
      end else if (hold_request) begin
         rsp_stall    <= 1'b1;
         hold_left    <= HOLD_CYCLES;
         hold_request = 1'b0;
      end else begin
         rsp_stall <= receiver_idles && ($urandom_range(99) < IDLE_PERCENT);
      end
   end

   function automatic void compare_field(input string field, input logic [31:0] want,
                                         input logic [31:0] got);
      if (got !== want) begin
         $error("%s: expected %0d, got %0d", field, want, got);
         mismatches++;
      end
   endfunction

   // Each result transfer is checked against the oldest outstanding outcome.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_outcomes.size() == 0) begin
            $error("result transfer with no item outstanding");
            mismatches++;
         end else begin
            oldest = expected_outcomes.pop_front();
            compare_field("knock_valid",   32'(oldest.knock_valid),
                          32'(rsp_data.knock_valid));
            compare_field("knock_sensor",  32'(oldest.knock_sensor),
                          32'(rsp_data.knock_sensor));
            compare_field("verdict",       32'(oldest.verdict),
                          32'(rsp_data.verdict));
            compare_field("is_solved",     32'(oldest.is_solved),
                          32'(rsp_data.is_solved));
            compare_field("attempt_count", 32'(oldest.attempt_count),
                          32'(rsp_data.attempt_count));
            compare_field("knocks_held",   32'(oldest.knocks_held),
                          32'(rsp_data.knocks_held));
            compare_field("window_open",   32'(oldest.window_open),
                          32'(rsp_data.window_open));
         end
      end
   end

   // Watchdog against a hung handshake.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("knock_pattern_detector regression: fail");
         $finish;
      end
   end

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      test_reset_defaults();
      test_knock_sequence();
      test_register_extremes();
      test_backpressure();
      test_random_traffic();
      drain();
      if (mismatches == 0) begin
         $display("knock_pattern_detector regression: pass");
      end else begin
         $display("knock_pattern_detector regression: fail");
      end
      $finish;
   end

endmodule
